// ===== src/sssd_pkg.sv =====
// Shared types, constants and lookup functions for the seven-segment scan driver.
`timescale 1ns / 1ps
package sssd_pkg;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int VALUE_W        = 24;
  localparam int DEC_W          = 3;
  localparam int DEC_CLAMP_W    = 2;
  localparam int SEG_W          = 8;
  localparam int SEL_W          = 4;
  localparam int IDX_W          = 2;
  localparam int FRAC_BITS      = 8;
  localparam int MAX_DECIMALS   = 3;
  localparam int SCALE_W        = 10;                 // holds 1000
  localparam int PROD_W         = VALUE_W + SCALE_W;
  localparam int WHOLE_W        = PROD_W - FRAC_BITS; // max rounded value < 2^26
  localparam int BCD_DIGITS     = 8;                  // 2^26 < 10^8
  localparam int BCD_W          = 4 * BCD_DIGITS;
  localparam int CNT_W          = $clog2(WHOLE_W);

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
  localparam logic [SEG_W-1:0] DP_MASK   = 8'h7F;

  typedef enum logic {
    REQ_SET  = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t              kind;
    logic [WHOLE_W-1:0]     whole;
    logic [DEC_CLAMP_W-1:0] dec;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_WRITE
  } back_state_t;

  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
    logic [SEG_W-1:0] g;
    unique case (d)
      4'h0: g = 8'hC0;
      4'h1: g = 8'hF9;
      4'h2: g = 8'hA4;
      4'h3: g = 8'hB0;
      4'h4: g = 8'h99;
      4'h5: g = 8'h92;
      4'h6: g = 8'h82;
      4'h7: g = 8'hF8;
      4'h8: g = 8'h80;
      4'h9: g = 8'h90;
      4'hA: g = 8'h88;
      4'hB: g = 8'h83;
      4'hC: g = 8'hC6;
      4'hD: g = 8'hA1;
      4'hE: g = 8'h86;
      4'hF: g = 8'h8E;
    endcase
    return g;
  endfunction

  function automatic logic [SCALE_W-1:0] pow10(input logic [DEC_CLAMP_W-1:0] e);
    logic [SCALE_W-1:0] s;
    unique case (e)
      2'd0: s = 10'd1;
      2'd1: s = 10'd10;
      2'd2: s = 10'd100;
      2'd3: s = 10'd1000;
    endcase
    return s;
  endfunction

endpackage

// ===== src/sssd_front.sv =====
// Front end: accepts transactions, clamps the decimal count, scales and rounds the value.
`timescale 1ns / 1ps
module sssd_front #(
  parameter int NUM_DIGITS = sssd_pkg::NUM_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [sssd_pkg::VALUE_W-1:0]  display_value,
  input  logic [sssd_pkg::DEC_W-1:0]    decimals,
  input  sssd_pkg::q_status_t           q_status,
  output logic                          push,
  output sssd_pkg::cmd_t                push_cmd
);

  localparam int MaxDec = (sssd_pkg::MAX_DECIMALS < NUM_DIGITS - 1) ?
                          sssd_pkg::MAX_DECIMALS : NUM_DIGITS - 1;

  logic                                 f_valid;
  sssd_pkg::req_kind_t                  f_kind;
  logic [sssd_pkg::PROD_W-1:0]          f_prod;
  logic [sssd_pkg::DEC_CLAMP_W-1:0]     f_dec;

  logic [sssd_pkg::DEC_CLAMP_W-1:0]     dec_c;
  logic [sssd_pkg::SCALE_W-1:0]         scale;
  logic [sssd_pkg::PROD_W-1:0]          prod;
  logic [sssd_pkg::PROD_W-1:0]          rounded;
  logic                                 load;

  assign dec_c = (decimals > sssd_pkg::DEC_W'(MaxDec)) ?
                 sssd_pkg::DEC_CLAMP_W'(MaxDec) : decimals[sssd_pkg::DEC_CLAMP_W-1:0];
  assign scale = sssd_pkg::pow10(dec_c);
  assign prod  = {{sssd_pkg::SCALE_W{1'b0}}, display_value} *
                 {{sssd_pkg::VALUE_W{1'b0}}, scale};

  assign push     = f_valid && !q_status.full;
  assign load     = !f_valid || !q_status.full;
  assign in_stall = !load;

  // round half up, then drop the fraction bits
  assign rounded = f_prod + (sssd_pkg::PROD_W'(1) << (sssd_pkg::FRAC_BITS - 1));

  assign push_cmd.kind  = f_kind;
  assign push_cmd.whole = rounded[sssd_pkg::PROD_W-1:sssd_pkg::FRAC_BITS];
  assign push_cmd.dec   = f_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      f_kind <= sssd_pkg::req_kind_t'(req_type);
      f_prod <= prod;
      f_dec  <= dec_c;
    end
  end

endmodule

// ===== src/sssd_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module sssd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sssd_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output sssd_pkg::cmd_t       head,
  output sssd_pkg::q_status_t  status
);

  sssd_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign head         = entries[rd_ptr];
  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/sssd_back.sv =====
// Back end: binary-to-BCD conversion, segment store, scan position and output register.
`timescale 1ns / 1ps
module sssd_back #(
  parameter int NUM_DIGITS = sssd_pkg::NUM_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sssd_pkg::cmd_t               head,
  input  sssd_pkg::q_status_t          q_status,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sssd_pkg::SEG_W-1:0]   segment_byte,
  output logic [sssd_pkg::SEL_W-1:0]   digit_select,
  output logic [sssd_pkg::IDX_W-1:0]   digit_index
);

  localparam int PosW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  sssd_pkg::back_state_t               state;
  sssd_pkg::back_state_t               state_next;

  logic [sssd_pkg::SEG_W-1:0]          store [NUM_DIGITS];
  logic [PosW-1:0]                     pos;
  logic [PosW-1:0]                     pos_next;
  logic [2:0]                          pos_ext;
  logic [7:0]                          pos_onehot;

  logic [sssd_pkg::WHOLE_W-1:0]        bin;
  logic [sssd_pkg::BCD_W-1:0]          bcd;
  logic [sssd_pkg::BCD_W-1:0]          bcd_adj;
  logic [sssd_pkg::DEC_CLAMP_W-1:0]    dec;
  logic [sssd_pkg::CNT_W-1:0]          cnt;

  logic                                out_free;
  logic                                tick_go;
  logic                                set_go;
  logic                                shift_go;
  logic                                write_go;

  assign out_free   = !out_valid || !out_stall;
  assign pos_next   = (pos == PosW'(NUM_DIGITS - 1)) ? '0 : pos + 1'b1;
  assign pos_ext    = 3'(pos_next);
  assign pos_onehot = 8'd1 << pos_ext;

  always_comb begin
    state_next = state;
    unique case (state)
      sssd_pkg::ST_IDLE: begin
        if (set_go) begin
          state_next = sssd_pkg::ST_CONVERT;
        end
      end
      sssd_pkg::ST_CONVERT: begin
        if (cnt == sssd_pkg::CNT_W'(sssd_pkg::WHOLE_W - 1)) begin
          state_next = sssd_pkg::ST_WRITE;
        end
      end
      sssd_pkg::ST_WRITE: begin
        state_next = sssd_pkg::ST_IDLE;
      end
      default: state_next = sssd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    tick_go  = 1'b0;
    set_go   = 1'b0;
    shift_go = 1'b0;
    write_go = 1'b0;
    unique case (state)
      sssd_pkg::ST_IDLE: begin
        if (q_status.valid) begin
          if (head.kind == sssd_pkg::REQ_TICK) begin
            tick_go = out_free;
            pop     = out_free;
          end else begin
            set_go = 1'b1;
            pop    = 1'b1;
          end
        end
      end
      sssd_pkg::ST_CONVERT: shift_go = 1'b1;
      sssd_pkg::ST_WRITE:   write_go = 1'b1;
      default: ;
    endcase
  end

  // double dabble: add 3 to every BCD digit of 5 or more before each shift
  always_comb begin
    for (int i = 0; i < sssd_pkg::BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sssd_pkg::ST_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        store[k] <= sssd_pkg::SEG_BLANK;
      end
    end else begin
      state <= state_next;
      if (tick_go) begin
        pos       <= pos_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // low NUM_DIGITS BCD digits are the value modulo 10^NUM_DIGITS
      if (write_go) begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
          store[k] <= sssd_pkg::glyph(bcd[4*(NUM_DIGITS-1-k) +: 4]) &
                      (((NUM_DIGITS - 1 - k) == int'(dec)) ? sssd_pkg::DP_MASK
                                                           : sssd_pkg::SEG_BLANK);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_go) begin
      bin <= head.whole;
      bcd <= '0;
      dec <= head.dec;
      cnt <= '0;
    end else if (shift_go) begin
      bcd <= {bcd_adj[sssd_pkg::BCD_W-2:0], bin[sssd_pkg::WHOLE_W-1]};
      bin <= {bin[sssd_pkg::WHOLE_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      segment_byte <= store[pos_next];
      digit_select <= ~pos_onehot[sssd_pkg::SEL_W-1:0];
      digit_index  <= pos_ext[sssd_pkg::IDX_W-1:0];
    end
  end

endmodule

// ===== src/seven_segment_scan_driver.sv =====
// Channel   Handshake           Payload
// in        in_valid/in_stall   req_type, display_value, decimals
// out       out_valid/out_stall segment_byte, digit_select, digit_index
//
// In the back end a refresh tick is taken straight from the idle state; a set-value transaction
// runs the convert state (the bit-serial BCD conversion loop), then the write state, then idle.
// Input is taken every cycle while the two-entry queue and front stage have room.
// Reset (rst, synchronous) blanks all digits and puts the scan position at digit 0.
// out_stall holds the output register; a tick at the queue head waits behind it,
// a set at the queue head still runs.
`timescale 1ns / 1ps
module seven_segment_scan_driver #(
  parameter int NUM_DIGITS = sssd_pkg::NUM_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [sssd_pkg::VALUE_W-1:0] display_value,
  input  logic [sssd_pkg::DEC_W-1:0]   decimals,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sssd_pkg::SEG_W-1:0]   segment_byte,
  output logic [sssd_pkg::SEL_W-1:0]   digit_select,
  output logic [sssd_pkg::IDX_W-1:0]   digit_index
);

  sssd_pkg::q_status_t q_status;
  sssd_pkg::cmd_t      push_cmd;
  sssd_pkg::cmd_t      head;
  logic                push;
  logic                pop;

  sssd_front #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .display_value (display_value),
    .decimals      (decimals),
    .q_status      (q_status),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  sssd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  sssd_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segment_byte (segment_byte),
    .digit_select (digit_select),
    .digit_index  (digit_index)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_status.valid)
    else $error("queue pop while empty");

  a_select_matches_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (NUM_DIGITS <= 4) |->
      ($countones(digit_select) == 3) && !digit_select[digit_index])
    else $error("digit select disagrees with digit index");

endmodule

// ===== verif/tb_seven_segment_scan_driver.sv =====
// Self-checking testbench for the seven-segment scan driver: value loads, scan ticks, backpressure.
`timescale 1ns / 1ps
module tb_seven_segment_scan_driver;

  localparam int RANDOM_ITEMS  = 1250;
  localparam int PAUSE_AT      = 800;   // sender drains the block here
  localparam int HOLD_AFTER    = 400;   // receiver long hold-off starts after this many inputs
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 80;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SHOWN_LIMIT   = 10;

  // active-low hex glyphs, digit 0 in the low byte
  localparam logic [16*8-1:0] GLYPH_ROM = {
    8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h90, 8'h80,
    8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  typedef struct packed {
    logic [sssd_pkg::SEG_W-1:0] seg;
    logic [sssd_pkg::SEL_W-1:0] sel;
    logic [sssd_pkg::IDX_W-1:0] idx;
  } scan_out_t;

  typedef struct packed {
    sssd_pkg::req_kind_t          kind;
    logic [sssd_pkg::VALUE_W-1:0] value;
    logic [sssd_pkg::DEC_W-1:0]   dec;
    logic                         has_want;
    scan_out_t                    want;
  } stim_row_t;

  localparam scan_out_t UNCHECKED = '0;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         req_type = 1'b0;
  logic [sssd_pkg::VALUE_W-1:0] display_value = '0;
  logic [sssd_pkg::DEC_W-1:0]   decimals = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [sssd_pkg::SEG_W-1:0]   segment_byte;
  logic [sssd_pkg::SEL_W-1:0]   digit_select;
  logic [sssd_pkg::IDX_W-1:0]   digit_index;

  // display model
  logic [sssd_pkg::SEG_W-1:0] shown [4];
  logic [1:0]                 scan_pos;
  scan_out_t                  pending_scans [$];

  int  mismatches = 0;
  int  inputs_taken = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  bit  long_hold_done = 1'b0;
  stim_row_t directed [25];

  seven_segment_scan_driver uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .display_value (display_value),
    .decimals      (decimals),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .segment_byte  (segment_byte),
    .digit_select  (digit_select),
    .digit_index   (digit_index)
  );

  always #4 clk = ~clk;

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= SHOWN_LIMIT) $display("MISMATCH: %s", what);
  endtask

  // scale by 10^dec, round half up, keep four digits, mark the point
  task automatic load_display(input logic [sssd_pkg::VALUE_W-1:0] value,
                              input logic [sssd_pkg::DEC_W-1:0] dec);
    logic [1:0]                  places;
    logic [sssd_pkg::PROD_W-1:0] scaled;
    logic [31:0]                 rest;
    int                          k;
    places = (dec > 3) ? 2'd3 : dec[1:0];
    scaled = sssd_pkg::PROD_W'(value);
    repeat (places) scaled = sssd_pkg::PROD_W'(scaled * 10);
    rest = 32'(((scaled + 128) >> sssd_pkg::FRAC_BITS) % 10000);
    for (k = 3; k >= 0; k--) begin
      shown[k] = GLYPH_ROM[(rest % 10) * 8 +: 8];
      rest = rest / 10;
    end
    shown[3 - places] = shown[3 - places] & sssd_pkg::DP_MASK;
  endtask

  task automatic advance_scan(output scan_out_t res);
    scan_pos = (scan_pos == 2'd3) ? 2'd0 : scan_pos + 2'd1;
    res.seg = shown[scan_pos];
    res.sel = ~(4'b0001 << scan_pos);
    res.idx = scan_pos;
  endtask

  // offer one transaction in bursts; predict once it is accepted
  task automatic offer(input stim_row_t row);
    int        gap;
    scan_out_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    req_type      <= row.kind;
    display_value <= row.value;
    decimals      <= row.dec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    inputs_taken++;
    if (row.kind == sssd_pkg::REQ_SET) begin
      load_display(row.value, row.dec);
    end else begin
      advance_scan(res);
      pending_scans.push_back(row.has_want ? row.want : res);
    end
  endtask

  // receiver stall pattern, with one long hold-off to fill the block
  initial begin
    int mode;
    int span;
    int phase;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (phase % 4) != 0;
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
        phase++;
      end
      if (!long_hold_done && inputs_taken >= HOLD_AFTER) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    scan_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scans.size() == 0) begin
        note_mismatch($sformatf("unexpected result seg=%h sel=%b idx=%0d",
                                segment_byte, digit_select, digit_index));
      end else begin
        want = pending_scans.pop_front();
        if (segment_byte !== want.seg)
          note_mismatch($sformatf("segment_byte exp %h got %h (digit %0d)",
                                  want.seg, segment_byte, want.idx));
        if (digit_select !== want.sel)
          note_mismatch($sformatf("digit_select exp %b got %b", want.sel, digit_select));
        if (digit_index !== want.idx)
          note_mismatch($sformatf("digit_index exp %0d got %0d", want.idx, digit_index));
      end
    end
  end

  // watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("seven_segment_scan_driver test failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    int        n;
    int        k;
    for (k = 0; k < 4; k++) shown[k] = sssd_pkg::SEG_BLANK;
    scan_pos = 2'd0;

    directed = '{
      // blank display after reset, first tick shows digit 1
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b1, '{8'hFF, 4'b1101, 2'd1}},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b1, '{8'hFF, 4'b1011, 2'd2}},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b1, '{8'hFF, 4'b0111, 2'd3}},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b1, '{8'hFF, 4'b1110, 2'd0}},
      // zero, point on the last digit
      '{sssd_pkg::REQ_SET,  24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b1, '{8'hC0, 4'b1101, 2'd1}},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b1, '{8'hC0, 4'b1011, 2'd2}},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b1, '{8'h40, 4'b0111, 2'd3}},
      // full scale, decimals clamped, overflow wraps to low four digits
      '{sssd_pkg::REQ_SET,  24'hFFFFFF, 3'd7, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'hFFFFFF, 3'd7, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'hFFFFFF, 3'd7, 1'b0, UNCHECKED},
      // exact half rounds up
      '{sssd_pkg::REQ_SET,  24'h000080, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_SET,  24'h000180, 3'd4, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_SET,  24'h000100, 3'd2, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_SET,  24'h555555, 3'd6, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED},
      '{sssd_pkg::REQ_TICK, 24'h000000, 3'd0, 1'b0, UNCHECKED}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) offer(directed[i]);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_scans.size() != 0) @(posedge clk);
        burst_left = 0;
      end
      row.kind = ($urandom_range(0, 9) < 7) ? sssd_pkg::REQ_TICK : sssd_pkg::REQ_SET;
      case ($urandom_range(0, 3))
        0: row.value = 24'($urandom_range(0, 1023));
        1: row.value = 24'($urandom_range(0, 65535) << 8);
        2: row.value = 24'(($urandom_range(0, 65535) << 8) | 32'h80);
        default: row.value = 24'($urandom());
      endcase
      row.dec = 3'($urandom_range(0, 7));
      row.has_want = 1'b0;
      row.want = UNCHECKED;
      offer(row);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("seven_segment_scan_driver test passed");
    end else begin
      $display("seven_segment_scan_driver test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sssd_pkg.sv
src/sssd_front.sv
src/sssd_queue.sv
src/sssd_back.sv
src/seven_segment_scan_driver.sv
verif/tb_seven_segment_scan_driver.sv
